[hw/rtl/tmi_pkg.sv]
`timescale 1ns / 1ps

package tmi_pkg;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_START  = 2'd1,
        CMD_STEP   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        OP_NOP   = 4'd0,
        OP_RIGHT = 4'd1,
        OP_LEFT  = 4'd2,
        OP_INC   = 4'd3,
        OP_DEC   = 4'd4,
        OP_OUT   = 4'd5,
        OP_IN    = 4'd6,
        OP_OPEN  = 4'd7,
        OP_CLOSE = 4'd8
    } op_t;

    typedef enum logic [2:0] {
        ST_EXEC      = 3'd0,
        ST_OUT       = 3'd1,
        ST_END       = 3'd2,
        ST_UNMATCHED = 3'd3,
        ST_EDGE      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_EXEC,
        FSM_SCAN_RD,
        FSM_SCAN_CK
    } fsm_t;

    localparam logic [7:0] SYM_RIGHT = 8'h3E;  // >
    localparam logic [7:0] SYM_LEFT  = 8'h3C;  // <
    localparam logic [7:0] SYM_INC   = 8'h2B;  // +
    localparam logic [7:0] SYM_DEC   = 8'h2D;  // -
    localparam logic [7:0] SYM_OUT   = 8'h2E;  // .
    localparam logic [7:0] SYM_IN    = 8'h2C;  // ,
    localparam logic [7:0] SYM_OPEN  = 8'h5B;  // [
    localparam logic [7:0] SYM_CLOSE = 8'h5D;  // ]

    // Commands from controller to datapath
    typedef struct packed {
        logic append;
        logic prog_clear;
        logic start;
        logic clr_step;
        logic fetch;
        logic exec;
        logic end_halt;
        logic scan_init;
        logic scan_rd;
        logic scan_ck;
        logic scan_fail;
        logic scan_done;
        logic emit;
    } ctl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic clear_done;
        logic run_end;
        logic jump;
        logic scan_ok;
        logic scan_match;
    } sts_t;

    function automatic op_t encode_symbol(input logic [7:0] ch);
        op_t op;
        unique case (ch)
            SYM_RIGHT: op = OP_RIGHT;
            SYM_LEFT:  op = OP_LEFT;
            SYM_INC:   op = OP_INC;
            SYM_DEC:   op = OP_DEC;
            SYM_OUT:   op = OP_OUT;
            SYM_IN:    op = OP_IN;
            SYM_OPEN:  op = OP_OPEN;
            SYM_CLOSE: op = OP_CLOSE;
            default:   op = OP_NOP;
        endcase
        return op;
    endfunction

endpackage

[hw/rtl/tmi_ctrl.sv]
`timescale 1ns / 1ps

module tmi_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  tmi_pkg::cmd_t cmd,
    input  logic          out_free,
    input  tmi_pkg::sts_t sts,
    output tmi_pkg::ctl_t ctl
);
    import tmi_pkg::*;

    fsm_t state_reg;
    fsm_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_CLEAR;  // tape starts zeroed: sweep it after reset
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            FSM_CLEAR: begin
                ctl.clr_step = 1'b1;
                if (sts.clear_done) begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (cmd)
                        CMD_APPEND: ctl.append = 1'b1;
                        CMD_CLEAR:  ctl.prog_clear = 1'b1;
                        CMD_START: begin
                            ctl.start  = 1'b1;
                            state_next = FSM_CLEAR;
                        end
                        CMD_STEP: begin
                            ctl.fetch  = 1'b1;
                            state_next = FSM_EXEC;
                        end
                        default: ;
                    endcase
                end
            end
            FSM_EXEC: begin
                priority if (sts.run_end) begin
                    if (out_free) begin
                        ctl.end_halt = 1'b1;
                        ctl.emit     = 1'b1;
                        state_next   = FSM_IDLE;
                    end
                end else if (sts.jump) begin
                    ctl.scan_init = 1'b1;
                    state_next    = FSM_SCAN_RD;
                end else begin
                    if (out_free) begin
                        ctl.exec   = 1'b1;
                        ctl.emit   = 1'b1;
                        state_next = FSM_IDLE;
                    end
                end
            end
            FSM_SCAN_RD: begin
                if (!sts.scan_ok) begin
                    if (out_free) begin
                        ctl.scan_fail = 1'b1;
                        ctl.emit      = 1'b1;
                        state_next    = FSM_IDLE;
                    end
                end else begin
                    ctl.scan_rd = 1'b1;
                    state_next  = FSM_SCAN_CK;
                end
            end
            FSM_SCAN_CK: begin
                if (sts.scan_match) begin
                    if (out_free) begin
                        ctl.scan_done = 1'b1;
                        ctl.emit      = 1'b1;
                        state_next    = FSM_IDLE;
                    end
                end else begin
                    ctl.scan_ck = 1'b1;
                    state_next  = FSM_SCAN_RD;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

endmodule

[hw/rtl/tmi_dp.sv]
`timescale 1ns / 1ps

module tmi_dp #(
    parameter int PROGRAM_DEPTH = 1024,
    parameter int TAPE_DEPTH    = 4096
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  tmi_pkg::ctl_t   ctl,
    input  logic [7:0]      symbol,
    input  logic [7:0]      input_byte,
    output tmi_pkg::sts_t   sts,
    output tmi_pkg::status_t res_status,
    output logic [7:0]      res_byte
);
    import tmi_pkg::*;

    localparam int PA = $clog2(PROGRAM_DEPTH);
    localparam int PW = PA + 1;
    localparam int TA = $clog2(TAPE_DEPTH);
    localparam logic [PW-1:0] PROG_FULL = PW'(PROGRAM_DEPTH);
    localparam logic [TA-1:0] TAPE_MID  = TA'(TAPE_DEPTH / 2);
    localparam logic [TA-1:0] TAPE_LAST = TA'(TAPE_DEPTH - 1);

    logic [3:0] prog_mem [PROGRAM_DEPTH];
    logic [7:0] tape_mem [TAPE_DEPTH];

    logic [PW-1:0] len_reg,   len_next;
    logic [PW-1:0] pc_reg,    pc_next;
    logic [TA-1:0] tp_reg,    tp_next;
    logic          halted_reg, halted_next;
    logic [TA-1:0] clr_cnt_reg, clr_cnt_next;
    logic [PW-1:0] cur_reg,   cur_next;   // scan cursor
    logic [PW-1:0] depth_reg, depth_next; // bracket nesting during scan
    logic          fwd_reg,   fwd_next;
    logic [7:0]    inb_reg;
    logic [3:0]    prog_rd_reg;
    logic [7:0]    cell_reg;

    op_t           op;
    logic          at_right, at_left, edge_hit;
    logic [PW-1:0] scan_addr;
    logic          prog_rd_en;
    logic [PA-1:0] prog_rd_addr;
    logic          tape_wr_en;
    logic [TA-1:0] tape_wr_addr;
    logic [7:0]    tape_wr_data;
    status_t       exec_status;

    assign op       = op_t'(prog_rd_reg);
    assign at_right = (tp_reg == TAPE_LAST);
    assign at_left  = (tp_reg == '0);
    assign edge_hit = ((op == OP_RIGHT) && at_right) || ((op == OP_LEFT) && at_left);
    assign scan_addr = fwd_reg ? (cur_reg + PW'(1)) : (cur_reg - PW'(1));

    assign sts.clear_done = (clr_cnt_reg == TAPE_LAST);
    assign sts.run_end    = halted_reg || (pc_reg >= len_reg);
    assign sts.jump       = ((op == OP_OPEN) && (cell_reg == 8'd0))
                         || ((op == OP_CLOSE) && (cell_reg != 8'd0));
    assign sts.scan_ok    = fwd_reg ? (scan_addr < len_reg) : (cur_reg != '0);
    assign sts.scan_match = (depth_reg == PW'(1))
                         && (fwd_reg ? (op == OP_CLOSE) : (op == OP_OPEN));

    always_comb begin
        unique case (op)
            OP_RIGHT: exec_status = at_right ? ST_EDGE : ST_EXEC;
            OP_LEFT:  exec_status = at_left ? ST_EDGE : ST_EXEC;
            OP_OUT:   exec_status = ST_OUT;
            default:  exec_status = ST_EXEC;
        endcase
    end

    always_comb begin
        priority if (ctl.end_halt) begin
            res_status = ST_END;
        end else if (ctl.scan_fail) begin
            res_status = ST_UNMATCHED;
        end else if (ctl.scan_done) begin
            res_status = ST_EXEC;
        end else begin
            res_status = exec_status;
        end
    end
    assign res_byte = (ctl.exec && (op == OP_OUT)) ? cell_reg : 8'd0;

    // Program memory port control
    assign prog_rd_en   = ctl.fetch || ctl.scan_rd;
    assign prog_rd_addr = ctl.fetch ? pc_reg[PA-1:0] : scan_addr[PA-1:0];

    // Tape write port: clearing sweep or a cell update
    always_comb begin
        tape_wr_en   = 1'b0;
        tape_wr_addr = tp_reg;
        tape_wr_data = 8'd0;
        if (ctl.clr_step) begin
            tape_wr_en   = 1'b1;
            tape_wr_addr = clr_cnt_reg;
        end else if (ctl.exec) begin
            unique case (op)
                OP_INC: begin
                    tape_wr_en   = 1'b1;
                    tape_wr_data = cell_reg + 8'd1;
                end
                OP_DEC: begin
                    tape_wr_en   = 1'b1;
                    tape_wr_data = cell_reg - 8'd1;
                end
                OP_IN: begin
                    tape_wr_en   = 1'b1;
                    tape_wr_data = inb_reg;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        len_next     = len_reg;
        pc_next      = pc_reg;
        tp_next      = tp_reg;
        halted_next  = halted_reg;
        clr_cnt_next = clr_cnt_reg;
        cur_next     = cur_reg;
        depth_next   = depth_reg;
        fwd_next     = fwd_reg;
        if (ctl.append && (len_reg < PROG_FULL)) begin
            len_next = len_reg + PW'(1);
        end
        if (ctl.prog_clear) begin
            len_next    = '0;
            pc_next     = '0;
            halted_next = 1'b1;
        end
        if (ctl.start) begin
            tp_next      = TAPE_MID;
            pc_next      = '0;
            halted_next  = 1'b0;
            clr_cnt_next = '0;
        end
        if (ctl.clr_step) begin
            clr_cnt_next = clr_cnt_reg + TA'(1);
        end
        if (ctl.end_halt || ctl.scan_fail) begin
            halted_next = 1'b1;
        end
        if (ctl.exec) begin
            if (edge_hit) begin
                halted_next = 1'b1;
            end else begin
                pc_next = pc_reg + PW'(1);
                if (op == OP_RIGHT) begin
                    tp_next = tp_reg + TA'(1);
                end else if (op == OP_LEFT) begin
                    tp_next = tp_reg - TA'(1);
                end
            end
        end
        if (ctl.scan_init) begin
            cur_next   = pc_reg;
            depth_next = PW'(1);
            fwd_next   = (op == OP_OPEN);
        end
        if (ctl.scan_rd) begin
            cur_next = scan_addr;
        end
        if (ctl.scan_ck) begin
            if (fwd_reg ? (op == OP_OPEN) : (op == OP_CLOSE)) begin
                depth_next = depth_reg + PW'(1);
            end else if (fwd_reg ? (op == OP_CLOSE) : (op == OP_OPEN)) begin
                depth_next = depth_reg - PW'(1);
            end
        end
        if (ctl.scan_done) begin
            pc_next = cur_reg + PW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            pc_reg      <= '0;
            tp_reg      <= TAPE_MID;
            halted_reg  <= 1'b1;
            clr_cnt_reg <= '0;
        end else begin
            len_reg     <= len_next;
            pc_reg      <= pc_next;
            tp_reg      <= tp_next;
            halted_reg  <= halted_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        depth_reg <= depth_next;
        fwd_reg   <= fwd_next;
        if (ctl.fetch) begin
            inb_reg <= input_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.append && (len_reg < PROG_FULL)) begin
            prog_mem[len_reg[PA-1:0]] <= 4'(encode_symbol(symbol));
        end
        if (prog_rd_en) begin
            prog_rd_reg <= prog_mem[prog_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (tape_wr_en) begin
            tape_mem[tape_wr_addr] <= tape_wr_data;
        end
        if (ctl.fetch) begin
            cell_reg <= tape_mem[tp_reg];
        end
    end

endmodule

[hw/rtl/tape_machine_interpreter.sv]
`timescale 1ns / 1ps

// Channel  Dir  tdata                          tuser
// s_       in   [7:0] symbol, [15:8] input_byte [1:0] command
// m_       out  [7:0] out_byte                  [2:0] status
//
// Append and clear act on acceptance; a step is accepted, then executes on the
// registered program and tape reads. A bracket scan reads, then checks, each
// symbol visited, and ends in the read state when no match is found. Start
// sweeps the tape one cell per cycle; the same sweep runs after reset.
// s_tready is low during a sweep, a scan, and while a step waits for a result
// held in the output register.
module tape_machine_interpreter #(
    parameter int PROGRAM_DEPTH = 1024,
    parameter int TAPE_DEPTH    = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] symbol, [15:8] input_byte
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [2:0]  m_tuser    // [2:0] status
);
    import tmi_pkg::*;

    ctl_t    ctl;
    sts_t    sts;
    status_t res_status;
    logic [7:0] res_byte;
    logic    out_free;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg;
    logic [2:0] m_status_reg;

    assign out_free = !m_valid_reg || m_tready;

    tmi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd_t'(s_tuser)),
        .out_free (out_free),
        .sts      (sts),
        .ctl      (ctl)
    );

    tmi_dp #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .TAPE_DEPTH    (TAPE_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .symbol     (s_tdata[7:0]),
        .input_byte (s_tdata[15:8]),
        .sts        (sts),
        .res_status (res_status),
        .res_byte   (res_byte)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctl.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.emit) begin
            m_byte_reg   <= res_byte;
            m_status_reg <= 3'(res_status);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_status_reg;

endmodule
